FILE: design/lcd4_pkg.sv
package lcd4_pkg;

   localparam int TPM_W = 20;
   localparam int MS_W = 7;
   localparam int STEP_W = 4;

   localparam logic [TPM_W-1:0] TPM_RESET = 20'd48000;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_CHAR = 2'd1;
   localparam logic [1:0] REQ_CMD = 2'd2;
   localparam logic [1:0] REQ_INIT = 2'd3;

   localparam logic [STEP_W-1:0] STEP_CMD_FIRST = 4'd4;
   localparam logic [STEP_W-1:0] STEP_CMD_LAST = 4'd11;
   localparam logic [STEP_W-1:0] STEP_WR_HI = 4'd12;
   localparam logic [STEP_W-1:0] STEP_WR_LO = 4'd13;

   localparam logic [MS_W-1:0] MS_POWER = 7'd100;
   localparam logic [MS_W-1:0] MS_PULSE = 7'd1;
   localparam logic [MS_W-1:0] MS_NIB_WAIT = 7'd5;
   localparam logic [MS_W-1:0] MS_CMD_WAIT = 7'd7;
   localparam logic [MS_W-1:0] MS_WR_WAIT = 7'd2;

   typedef logic [7:0] cmd_table_type [4];
   localparam cmd_table_type INIT_CMDS = '{8'h28, 8'h0C, 8'h06, 8'h01};
   localparam logic [3:0] INIT_NIB_LAST = 4'h2;
   localparam logic [3:0] INIT_NIB = 4'h3;

   // nibble put on D4..D7 for a given step
   function automatic logic [3:0] step_nibble(input logic [STEP_W-1:0] s,
                                              input logic [7:0] b);
      logic [STEP_W-1:0] off;
      logic [7:0] c;
      off = s - STEP_CMD_FIRST;
      c = INIT_CMDS[off[2:1]];
      priority if (s < STEP_CMD_FIRST) begin
         step_nibble = (s == STEP_CMD_FIRST - 4'd1) ? INIT_NIB_LAST : INIT_NIB;
      end else if (s <= STEP_CMD_LAST) begin
         step_nibble = off[0] ? c[3:0] : c[7:4];
      end else if (s == STEP_WR_HI) begin
         step_nibble = b[7:4];
      end else begin
         step_nibble = b[3:0];
      end
   endfunction

   // wait after the enable pulse, zero means go straight to the next step
   function automatic logic [MS_W-1:0] step_post_ms(input logic [STEP_W-1:0] s);
      logic [STEP_W-1:0] off;
      off = s - STEP_CMD_FIRST;
      priority if (s < STEP_CMD_FIRST) begin
         step_post_ms = MS_NIB_WAIT;
      end else if (s <= STEP_CMD_LAST) begin
         step_post_ms = off[0] ? MS_CMD_WAIT : '0;
      end else if (s == STEP_WR_HI) begin
         step_post_ms = '0;
      end else begin
         step_post_ms = MS_WR_WAIT;
      end
   endfunction

endpackage

FILE: design/char_lcd_4bit_write_sequencer.sv
// channel   ports                          direction
// req       req_valid/ready, req_type,     in   one timebase tick, optional request
//           req_data_byte
// rsp       rsp_valid/ready, rsp_lcd_rs,   out  pin levels and status after the tick
//           rsp_lcd_e, rsp_lcd_data,
//           rsp_busy_res, rsp_rejected
// csr       csr_valid/ready,               in   ticks per millisecond
//           csr_ticks_per_ms
//
// one request per clock: the whole tick is one pass of logic between the state
// registers, which also hold the response, so a new request is taken every cycle
// while rsp_ready is high or no response is waiting.
// a stall on rsp holds req_ready low and freezes the sequence; time only moves on
// accepted requests. synchronous reset gives idle, pins low and 48000 ticks per ms.
module char_lcd_4bit_write_sequencer import lcd4_pkg::*; #(
   parameter int TICK_COUNT_BITS = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_type,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_lcd_rs,
   output logic             rsp_lcd_e,
   output logic [3:0]       rsp_lcd_data,
   output logic             rsp_busy_res,
   output logic             rsp_rejected,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TPM_W-1:0] csr_ticks_per_ms
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_POWER = 3'd1;
   localparam logic [2:0] PH_SETUP = 3'd2;
   localparam logic [2:0] PH_PULSE = 3'd3;
   localparam logic [2:0] PH_HOLD = 3'd4;

   localparam int CMP_W = (TICK_COUNT_BITS + 1 > TPM_W) ? TICK_COUNT_BITS + 1 : TPM_W;

   logic [TPM_W-1:0]           tpm_ff;
   logic [2:0]                 phase_ff, phase_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [MS_W-1:0]            ms_ff, ms_in;
   logic [TICK_COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       rs_ff, rs_in;
   logic                       e_ff, e_in;
   logic [3:0]                 nib_ff, nib_in;
   logic                       rej_ff, rej_in;
   logic                       rsp_valid_ff;

   logic                       req_fire;
   logic [TPM_W-1:0]           tpm_eff;
   logic [TICK_COUNT_BITS:0]   cnt_plus;
   logic                       ms_end;
   logic [TICK_COUNT_BITS-1:0] tmr_cnt;
   logic [MS_W-1:0]            tmr_ms;
   logic                       tmr_done;
   logic [MS_W-1:0]            post_ms;
   logic [STEP_W-1:0]          step_next;
   logic                       seq_last;
   logic                       was_busy;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // millisecond prescaler, also ends the millisecond when the counter would wrap
   assign tpm_eff = (tpm_ff == '0) ? TPM_W'(1) : tpm_ff;
   assign cnt_plus = {1'b0, cnt_ff} + (TICK_COUNT_BITS + 1)'(1);
   assign ms_end = (CMP_W'(cnt_plus) >= CMP_W'(tpm_eff)) || cnt_plus[TICK_COUNT_BITS];
   assign tmr_cnt = ms_end ? '0 : cnt_plus[TICK_COUNT_BITS-1:0];
   assign tmr_ms = (ms_end && ms_ff != '0) ? ms_ff - MS_W'(1) : ms_ff;
   assign tmr_done = ms_end && (tmr_ms == '0);

   assign post_ms = step_post_ms(step_ff);
   assign step_next = step_ff + STEP_W'(1);
   assign seq_last = (step_ff == STEP_CMD_LAST) || (step_ff >= STEP_WR_LO);
   assign was_busy = phase_ff != PH_IDLE;

   always_comb begin
      phase_in = phase_ff;
      step_in = step_ff;
      ms_in = ms_ff;
      cnt_in = cnt_ff;
      byte_in = byte_ff;
      rs_in = rs_ff;
      e_in = e_ff;
      nib_in = nib_ff;
      rej_in = 1'b0;

      unique case (phase_ff)
         PH_POWER: begin
            ms_in = tmr_ms;
            cnt_in = tmr_cnt;
            if (tmr_done) begin
               phase_in = PH_SETUP;
               step_in = '0;
               e_in = 1'b0;
               nib_in = step_nibble('0, byte_ff);
            end
         end
         PH_SETUP: begin
            phase_in = PH_PULSE;
            e_in = 1'b1;
            ms_in = MS_PULSE;
            cnt_in = '0;
         end
         PH_PULSE, PH_HOLD: begin
            ms_in = tmr_ms;
            cnt_in = tmr_cnt;
            if (tmr_done) begin
               e_in = 1'b0;
               if (phase_ff == PH_PULSE && post_ms != '0) begin
                  phase_in = PH_HOLD;
                  ms_in = post_ms;
                  cnt_in = '0;
               end else if (seq_last) begin
                  phase_in = PH_IDLE;
                  step_in = '0;
               end else begin
                  phase_in = PH_SETUP;
                  step_in = step_next;
                  nib_in = step_nibble(step_next, byte_ff);
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (req_type != REQ_TICK) begin
         if (was_busy) begin
            rej_in = 1'b1;
         end else if (req_type == REQ_INIT) begin
            phase_in = PH_POWER;
            step_in = '0;
            e_in = 1'b0;
            rs_in = 1'b0;
            ms_in = MS_POWER;
            cnt_in = '0;
         end else begin
            byte_in = req_data_byte;
            rs_in = (req_type == REQ_CHAR);
            phase_in = PH_SETUP;
            step_in = STEP_WR_HI;
            e_in = 1'b0;
            nib_in = step_nibble(STEP_WR_HI, req_data_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= TPM_RESET;
         phase_ff <= PH_IDLE;
         step_ff <= '0;
         ms_ff <= '0;
         cnt_ff <= '0;
         byte_ff <= '0;
         rs_ff <= 1'b0;
         e_ff <= 1'b0;
         nib_ff <= '0;
         rej_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            tpm_ff <= csr_ticks_per_ms;
         end
         if (req_fire) begin
            phase_ff <= phase_in;
            step_ff <= step_in;
            ms_ff <= ms_in;
            cnt_ff <= cnt_in;
            byte_ff <= byte_in;
            rs_ff <= rs_in;
            e_ff <= e_in;
            nib_ff <= nib_in;
            rej_ff <= rej_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // the state registers are the response register
   assign rsp_valid = rsp_valid_ff;
   assign rsp_lcd_rs = rs_ff;
   assign rsp_lcd_e = e_ff;
   assign rsp_lcd_data = nib_ff;
   assign rsp_busy_res = phase_ff != PH_IDLE;
   assign rsp_rejected = rej_ff;

`ifndef SYNTHESIS
   a_e_only_in_pulse: assert property (@(posedge clock) disable iff (reset)
      e_ff |-> (phase_ff == PH_PULSE))
      else $error("enable high outside the pulse phase");

   a_busy_request_rejected: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type != REQ_TICK && phase_ff != PH_IDLE) |=> rej_ff)
      else $error("request while busy was not flagged");

   a_power_wait_pins_low: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_POWER) |-> (!rs_ff && !e_ff))
      else $error("rs or e high during power wait");
`endif

endmodule
